/* src/base3_float_add_multiply_top_macros.svh */
// Assertion macros used by the checker of the base-3 floating-point unit.
`ifndef BASE3_FLOAT_ADD_MULTIPLY_TOP_MACROS_SVH
`define BASE3_FLOAT_ADD_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, switched off while rst is high.
`define B3FAM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base3 float unit check failed");

// Next-cycle implication, switched off while rst is high.
`define B3FAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base3 float unit check failed");

`endif

/* src/b3fam_pkg.sv */
// Package with widths, codes and the power-of-three table of the base-3 floating-point unit.
`default_nettype none

package b3fam_pkg;

   localparam int MANT_W              = 64;
   localparam int EXP_W               = 32;
   localparam int HALF_W              = MANT_W / 2;
   localparam int POW3_COUNT          = 39;
   localparam int POW3_IDX_W          = $clog2(POW3_COUNT);
   localparam int ALIGN_LIMIT_DEFAULT = 39;
   localparam int REQ_DATA_W          = 2 * MANT_W + 2 * EXP_W;
   localparam int RSP_DATA_W          = MANT_W + EXP_W;

   typedef enum logic {
      FUNC_ADD = 1'b0,
      FUNC_MUL = 1'b1
   } func_type;

   typedef logic [POW3_COUNT-1:0][MANT_W-1:0] pow3_table_type;

   // Evaluated at elaboration only, to fill the constant table.
   function automatic pow3_table_type build_pow3_table();
      pow3_table_type tbl;
      logic [MANT_W-1:0] p;
      p = MANT_W'(1);
      for (int i = 0; i < POW3_COUNT; i++) begin
         tbl[i] = p;
         p      = p * MANT_W'(3);
      end
      return tbl;
   endfunction

   localparam pow3_table_type POW3_TABLE = build_pow3_table();

endpackage

`default_nettype wire

/* src/base3_float_add_multiply_top.sv */
// Path: a word accepted on req passes the input, operand select, partial product and result
// registers in that order before it is shown on rsp.
// Throughput: one word per cycle while rsp is not stalled; four register stages (input,
// operand select, partial products, result), the depth being set by the 64-bit multiplier
// split into 32-bit parts. A stall on rsp holds every stage at once.
// Reset (synchronous, active high) clears all stage valid flags; data registers keep values.
`default_nettype none

module base3_float_add_multiply_top #(
   parameter int ALIGN_LIMIT = b3fam_pkg::ALIGN_LIMIT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // req_tdata fields from bit 0: mant_a[63:0], exp_a[95:64], mant_b[159:96], exp_b[191:160]
   input  wire logic [b3fam_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields from bit 0: func
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // rsp_tdata fields from bit 0: res_mant[63:0], res_exp[95:64]
   output logic [b3fam_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import b3fam_pkg::*;

   logic advance;

   // Input stage.
   logic              valid_in_ff;
   func_type          func_ff;
   logic [MANT_W-1:0] mant_a_ff, mant_b_ff;
   logic [EXP_W-1:0]  exp_a_ff, exp_b_ff;

   // Operand stage.
   logic              valid_op_ff;
   logic [MANT_W-1:0] op_x_ff, op_x_in;
   logic [MANT_W-1:0] op_y_ff, op_y_in;
   logic [MANT_W-1:0] op_addend_ff, op_addend_in;
   logic [EXP_W-1:0]  op_exp_ff, op_exp_in;

   // Partial product stage.
   logic              valid_pp_ff;
   logic [MANT_W-1:0] pp_ll_ff, pp_ll_in;
   logic [HALF_W-1:0] pp_lh_ff, pp_lh_in;
   logic [HALF_W-1:0] pp_hl_ff, pp_hl_in;
   logic [MANT_W-1:0] pp_addend_ff;
   logic [EXP_W-1:0]  pp_exp_ff;

   // Result stage.
   logic              valid_out_ff;
   logic [MANT_W-1:0] res_mant_ff, res_mant_in;
   logic [EXP_W-1:0]  res_exp_ff;

   // Alignment signals.
   logic [EXP_W:0]        exp_a_ext, exp_b_ext, diff_ab, diff_ba;
   logic                  a_larger, swallow;
   logic [EXP_W-1:0]      shift_dist;
   logic [POW3_IDX_W-1:0] pow3_idx;
   logic [HALF_W-1:0]     cross_sum;

   assign advance    = !valid_out_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_out_ff;
   assign rsp_tdata  = {res_exp_ff, res_mant_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_in_ff  <= 1'b0;
         valid_op_ff  <= 1'b0;
         valid_pp_ff  <= 1'b0;
         valid_out_ff <= 1'b0;
      end else if (advance) begin
         valid_in_ff  <= req_tvalid;
         valid_op_ff  <= valid_in_ff;
         valid_pp_ff  <= valid_op_ff;
         valid_out_ff <= valid_pp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         func_ff      <= func_type'(req_tuser);
         mant_a_ff    <= req_tdata[MANT_W-1:0];
         exp_a_ff     <= req_tdata[MANT_W+EXP_W-1:MANT_W];
         mant_b_ff    <= req_tdata[2*MANT_W+EXP_W-1:MANT_W+EXP_W];
         exp_b_ff     <= req_tdata[REQ_DATA_W-1:2*MANT_W+EXP_W];
         op_x_ff      <= op_x_in;
         op_y_ff      <= op_y_in;
         op_addend_ff <= op_addend_in;
         op_exp_ff    <= op_exp_in;
         pp_ll_ff     <= pp_ll_in;
         pp_lh_ff     <= pp_lh_in;
         pp_hl_ff     <= pp_hl_in;
         pp_addend_ff <= op_addend_ff;
         pp_exp_ff    <= op_exp_ff;
         res_mant_ff  <= res_mant_in;
         res_exp_ff   <= pp_exp_ff;
      end
   end

   // The exponent difference is taken exactly in one extra bit, both ways round.
   always_comb begin
      exp_a_ext  = {exp_a_ff[EXP_W-1], exp_a_ff};
      exp_b_ext  = {exp_b_ff[EXP_W-1], exp_b_ff};
      diff_ab    = exp_a_ext - exp_b_ext;
      diff_ba    = exp_b_ext - exp_a_ext;
      a_larger   = !diff_ab[EXP_W] && (diff_ab != '0);
      shift_dist = a_larger ? diff_ab[EXP_W-1:0] : diff_ba[EXP_W-1:0];
      swallow    = shift_dist >= EXP_W'(ALIGN_LIMIT);
      pow3_idx   = swallow ? '0 : shift_dist[POW3_IDX_W-1:0];
   end

   // Every operation becomes x * y + addend. Equal exponents fall out as a shift of
   // nothing, since the table's first entry is one.
   always_comb begin
      case (func_ff)
         FUNC_MUL: begin
            op_x_in      = mant_a_ff;
            op_y_in      = mant_b_ff;
            op_addend_in = '0;
            op_exp_in    = exp_a_ff + exp_b_ff;
         end
         default: begin
            op_x_in      = a_larger ? mant_a_ff : mant_b_ff;
            op_y_in      = POW3_TABLE[pow3_idx];
            if (swallow) begin
               op_addend_in = '0;
               op_exp_in    = a_larger ? exp_a_ff : exp_b_ff;
            end else begin
               op_addend_in = a_larger ? mant_b_ff : mant_a_ff;
               op_exp_in    = a_larger ? exp_b_ff : exp_a_ff;
            end
         end
      endcase
   end

   // Only the low 64 bits of the product are kept, so the high-by-high part drops out
   // and the cross terms are needed to 32 bits only.
   assign pp_ll_in = MANT_W'(op_x_ff[HALF_W-1:0]) * MANT_W'(op_y_ff[HALF_W-1:0]);
   assign pp_lh_in = op_x_ff[HALF_W-1:0] * op_y_ff[MANT_W-1:HALF_W];
   assign pp_hl_in = op_x_ff[MANT_W-1:HALF_W] * op_y_ff[HALF_W-1:0];

   assign cross_sum   = pp_lh_ff + pp_hl_ff;
   assign res_mant_in = pp_ll_ff + {cross_sum, {HALF_W{1'b0}}} + pp_addend_ff;

endmodule

`default_nettype wire

/* src/b3fam_checker.sv */
// Port-level checker of the base-3 floating-point unit, bound to its top level.
`default_nettype none
`include "base3_float_add_multiply_top_macros.svh"

module b3fam_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   // req_tdata fields from bit 0: mant_a, exp_a, mant_b, exp_b
   input wire logic [b3fam_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields from bit 0: func
   input wire logic                             req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   // rsp_tdata fields from bit 0: res_mant, res_exp
   input wire logic [b3fam_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import b3fam_pkg::*;

   localparam int STAGES = 4;

   logic [2:0] outstanding_ff, outstanding_in;
   logic       req_word, rsp_word;
   logic       unused_inputs;

   assign req_word      = req_tvalid && req_tready;
   assign rsp_word      = rsp_tvalid && rsp_tready;
   assign unused_inputs = ^{req_tdata, req_tuser};

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_word && !rsp_word) begin
         outstanding_in = outstanding_ff + 3'd1;
      end else if (rsp_word && !req_word) begin
         outstanding_in = outstanding_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `B3FAM_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `B3FAM_ASSERT_IMP(a_rsp_has_source, clock, reset, rsp_tvalid, outstanding_ff != 3'd0)
   `B3FAM_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1 || unused_inputs, outstanding_ff <= 3'(STAGES))
   `B3FAM_ASSERT_IMP(a_ready_follows_rsp, clock, reset, rsp_tready, req_tready)
   `B3FAM_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind base3_float_add_multiply_top b3fam_checker u_b3fam_checker (.*);

`default_nettype wire

/* tb/base3_float_add_multiply_top_tb.sv */
// Testbench for the base-3 floating-point add/multiply unit: random and corner-case operands.
module base3_float_add_multiply_top_tb;
   import b3fam_pkg::*;

   localparam int ALIGN_SPAN = 39;
   localparam int HOLD_CYCLES = 150;
   localparam int RANDOM_WORDS = 750;
   localparam logic signed [63:0] MANT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MANT_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] EXP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] EXP_MIN = 32'sh8000_0000;

   typedef struct {
      func_type op;
      logic signed [63:0] mant_a;
      logic signed [31:0] exp_a;
      logic signed [63:0] mant_b;
      logic signed [31:0] exp_b;
   } operand_word_type;

   typedef struct {
      logic signed [63:0] mant;
      logic signed [31:0] exp;
   } float_value_type;

   // Keeps the expected base-3 results in order and checks each word returned by the unit.
   class float_result_ledger;
      float_value_type pending_results[$];
      int noted;
      int checked;
      int errors;
      int adds;
      int aligned;
      int passed_through;
      int multiplies;

      function logic [63:0] power_of_three(int n);
         logic [63:0] p;
         p = 64'd1;
         for (int i = 0; i < n; i++) p = p * 64'd3;
         return p;
      endfunction

      function float_value_type evaluate(operand_word_type w);
         float_value_type r;
         longint exp_gap;
         exp_gap = longint'(w.exp_a) - longint'(w.exp_b);
         if (w.op == FUNC_MUL) begin
            multiplies++;
            r.mant = w.mant_a * w.mant_b;
            r.exp  = w.exp_a + w.exp_b;
         end else begin
            adds++;
            if (exp_gap == 0) begin
               r.mant = w.mant_a + w.mant_b;
               r.exp  = w.exp_a;
            end else if (exp_gap >= ALIGN_SPAN) begin
               passed_through++;
               r.mant = w.mant_a;
               r.exp  = w.exp_a;
            end else if (exp_gap <= -ALIGN_SPAN) begin
               passed_through++;
               r.mant = w.mant_b;
               r.exp  = w.exp_b;
            end else if (exp_gap > 0) begin
               aligned++;
               r.mant = w.mant_a * power_of_three(int'(exp_gap)) + w.mant_b;
               r.exp  = w.exp_b;
            end else begin
               aligned++;
               r.mant = w.mant_a + w.mant_b * power_of_three(int'(-exp_gap));
               r.exp  = w.exp_a;
            end
         end
         return r;
      endfunction

      function void note_operands(operand_word_type w);
         noted++;
         pending_results.push_back(evaluate(w));
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] word);
         float_value_type want;
         logic signed [63:0] got_mant;
         logic signed [31:0] got_exp;
         got_mant = word[63:0];
         got_exp  = word[95:64];
         if (pending_results.size() == 0) begin
            $error("result word with nothing pending: res_mant %0d res_exp %0d",
                   got_mant, got_exp);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got_mant !== want.mant) begin
            $error("res_mant mismatch: expected %0d, actual %0d", want.mant, got_mant);
            errors++;
         end
         if (got_exp !== want.exp) begin
            $error("res_exp mismatch: expected %0d, actual %0d", want.exp, got_exp);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   float_result_ledger ledger;
   bit hold_off;
   int sent;
   int input_stall_cycles;

   base3_float_add_multiply_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Offers one word, after a random gap outside bursts and hold-off, and waits until it is taken.
   task automatic send_operands(func_type op, logic signed [63:0] ma, logic signed [31:0] ea,
                                logic signed [63:0] mb, logic signed [31:0] eb);
      operand_word_type w;
      int gap;
      w.op = op;
      w.mant_a = ma;
      w.exp_a = ea;
      w.mant_b = mb;
      w.exp_b = eb;
      gap = (hold_off || sent % 64 < 16) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {eb, mb, ea, ma};
      do begin
         @(posedge clock);
         if (!req_tready) input_stall_cycles++;
      end while (!req_tready);
      ledger.note_operands(w);
      sent++;
   endtask

   function automatic logic signed [63:0] draw_mantissa();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         6, 7: return $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
         8: begin
            case ($urandom_range(0, 3))
               0: return MANT_MAX;
               1: return MANT_MIN;
               2: return 64'sd0;
               default: return -64'sd1;
            endcase
         end
         9: return $signed(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic signed [31:0] draw_exponent();
      if ($urandom_range(0, 1) == 0) return $signed(32'($urandom_range(0, 200))) - 32'sd100;
      return $urandom;
   endfunction

   task automatic send_random_word();
      func_type op;
      logic signed [31:0] ea;
      logic signed [31:0] eb;
      int kind;
      op = func_type'($urandom_range(0, 1));
      ea = draw_exponent();
      kind = $urandom_range(0, 9);
      // Most pairs sit close together so that the alignment path is exercised well.
      if (kind < 3) eb = ea;
      else if (kind < 7) eb = ea + ($signed(32'($urandom_range(0, 90))) - 32'sd45);
      else eb = draw_exponent();
      send_operands(op, draw_mantissa(), ea, draw_mantissa(), eb);
   endtask

   initial begin
      ledger = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_operands(FUNC_ADD, 64'sd5, 32'sd0, 64'sd7, 32'sd0);
      send_operands(FUNC_ADD, MANT_MAX, 32'sd3, 64'sd1, 32'sd3);
      send_operands(FUNC_ADD, MANT_MIN, EXP_MIN, MANT_MIN, EXP_MIN);
      send_operands(FUNC_ADD, 64'sd1, 32'sd38, -64'sd1, 32'sd0);
      send_operands(FUNC_ADD, 64'sd1, 32'sd39, -64'sd1, 32'sd0);
      send_operands(FUNC_ADD, 64'sd9, 32'sd40, 64'sd4, 32'sd0);
      send_operands(FUNC_ADD, 64'sd2, -32'sd20, 64'sd3, 32'sd18);
      send_operands(FUNC_ADD, 64'sd2, -32'sd20, 64'sd3, 32'sd19);
      send_operands(FUNC_ADD, 64'sd11, EXP_MAX, 64'sd12, EXP_MIN);
      send_operands(FUNC_ADD, 64'sd11, EXP_MIN, 64'sd12, EXP_MAX);
      send_operands(FUNC_ADD, -64'sd6, 32'sd1, -64'sd8, 32'sd0);
      send_operands(FUNC_ADD, MANT_MAX, 32'sd38, MANT_MAX, 32'sd0);
      send_operands(FUNC_ADD, 64'sd7, EXP_MAX, 64'sd1, EXP_MAX - 32'sd38);
      send_operands(FUNC_ADD, 64'sd7, EXP_MIN, 64'sd1, EXP_MIN + 32'sd37);
      send_operands(FUNC_ADD, 64'sd0, 32'sd0, 64'sd0, 32'sd0);
      send_operands(FUNC_ADD, -64'sd1, -32'sd1, -64'sd1, -32'sd1);
      send_operands(FUNC_MUL, 64'sd3, 32'sd2, -64'sd4, 32'sd5);
      send_operands(FUNC_MUL, MANT_MAX, 32'sd0, MANT_MAX, 32'sd0);
      send_operands(FUNC_MUL, MANT_MIN, 32'sd1, -64'sd1, 32'sd1);
      send_operands(FUNC_MUL, 64'sd2, EXP_MAX, 64'sd5, 32'sd1);
      send_operands(FUNC_MUL, 64'sd2, EXP_MIN, 64'sd5, -32'sd1);
      send_operands(FUNC_MUL, 64'sd0, EXP_MAX, MANT_MIN, EXP_MAX);
      send_operands(FUNC_MUL, -64'sd1, -32'sd1, -64'sd1, -32'sd1);

      repeat (RANDOM_WORDS) send_random_word();
      req_tvalid <= 1'b0;

      while (ledger.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d results: %0d adds (%0d aligned, %0d passed through), %0d multiplies.",
               ledger.checked, ledger.adds, ledger.aligned, ledger.passed_through,
               ledger.multiplies);
      $display("Input was stalled for %0d cycles, including a %0d-cycle output hold-off.",
               input_stall_cycles, HOLD_CYCLES);
      if (ledger.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: random back-pressure between words, and one long hold-off when asked.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = (ledger.checked % 48 >= 36) ? 0 : $urandom_range(0, 10);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            while (hold_off) @(posedge clock);
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         ledger.check_result(rsp_tdata);
      end
   end

   // Once the run is well under way, the output stops taking words long enough to back up the pipeline.
   initial begin
      hold_off = 1'b0;
      wait (ledger != null);
      while (ledger.noted < 400) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
